// File: sv/virtio_mmio_register_block_assert.svh
// ----------------------------------------------------------------------------
// virtio_mmio_register_block_assert.svh
// Assertion macros shared by the checker of the virtio-mmio register block.
// ----------------------------------------------------------------------------
`ifndef VIRTIO_MMIO_REGISTER_BLOCK_ASSERT_SVH
`define VIRTIO_MMIO_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VMMIO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VMMIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/vmmio_pkg.sv
// ----------------------------------------------------------------------------
// vmmio_pkg
// Types, register offsets and codes of the virtio-mmio register block.
// ----------------------------------------------------------------------------
package vmmio_pkg;

    // Input item: one bus access or an interrupt event
    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
        logic [3:0]  access_size;
    } t_item;

    // Result item: one per input item
    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  error_code;
        logic        notify_valid;
        logic        notify_queue;
        logic        reset_done;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;
    } t_cmd;

    // Item functions
    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_IRQ   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SIZE      = 3'd1;
    localparam logic [2:0] ERR_WO_READ   = 3'd2;
    localparam logic [2:0] ERR_RO_WRITE  = 3'd3;
    localparam logic [2:0] ERR_BAD_OFF   = 3'd4;
    localparam logic [2:0] ERR_CFG_SPACE = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEVICE_ID  = 3'd0;
    localparam logic [2:0] CFG_VENDOR_ID  = 3'd1;
    localparam logic [2:0] CFG_FEATURES   = 3'd2;
    localparam logic [2:0] CFG_NUM_QUEUES = 3'd3;
    localparam logic [2:0] CFG_QUEUE_MAX  = 3'd4;

    // Register map (version 2)
    localparam logic [11:0] OFF_MAGIC         = 12'h000;
    localparam logic [11:0] OFF_VERSION       = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID     = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID     = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT      = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL  = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT      = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL  = 12'h024;
    localparam logic [11:0] OFF_QUEUE_SEL     = 12'h030;
    localparam logic [11:0] OFF_QUEUE_NUM_MAX = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM     = 12'h038;
    localparam logic [11:0] OFF_QUEUE_READY   = 12'h044;
    localparam logic [11:0] OFF_QUEUE_NOTIFY  = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS    = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK       = 12'h064;
    localparam logic [11:0] OFF_STATUS        = 12'h070;
    localparam logic [11:0] OFF_DESC_LO       = 12'h080;
    localparam logic [11:0] OFF_DESC_HI       = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO      = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI      = 12'h094;
    localparam logic [11:0] OFF_USED_LO       = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI       = 12'h0a4;
    localparam logic [11:0] OFF_CFG_GEN       = 12'h0fc;
    localparam logic [11:0] CONFIG_BASE       = 12'h100;

    // Fixed values
    localparam logic [31:0] MAGIC_WORD    = 32'h7472_6976;
    localparam logic [31:0] VERSION_WORD  = 32'd2;
    localparam logic [3:0]  ACCESS_BYTES  = 4'd4;
    localparam int          EVENT_IDX_BIT = 29;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_DEVICE_ID  = 8'd2;
    localparam logic [1:0]  RST_NUM_QUEUES = 2'd1;
    localparam logic [15:0] RST_QUEUE_MAX  = 16'd256;

endpackage

// File: sv/vmmio_ctrl.sv
// ----------------------------------------------------------------------------
// vmmio_ctrl
// Handshake controller: takes items, issues execute, strobes the result.
// ----------------------------------------------------------------------------
module vmmio_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output vmmio_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // No item is taken while reset is held
    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    // Datapath executes the item in the cycle it is taken
    assign o_cmd.exec = accept;

    // Result is shown in the cycle after the item was taken
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_RESP;
            end
            S_RESP: begin
                if (!accept) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_done = (r_state == S_RESP);

endmodule

// File: sv/vmmio_dp.sv
// ----------------------------------------------------------------------------
// vmmio_dp
// Register file, access decode and result register of the register block.
// ----------------------------------------------------------------------------
module vmmio_dp #(
    parameter int MAX_QUEUES = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vmmio_pkg::t_cmd     i_cmd,
    input  vmmio_pkg::t_item    i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output vmmio_pkg::t_result  o_result
);

    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

    // Configuration registers
    logic [7:0]  r_dev_id;
    logic [31:0] r_vendor;
    logic [63:0] r_offered;
    logic [1:0]  r_num_q;
    logic [15:0] r_q_max;

    // Device state
    logic [31:0] r_status,   n_status;
    logic [31:0] r_irq,      n_irq;
    logic        r_dev_sel,  n_dev_sel;
    logic        r_drv_sel,  n_drv_sel;
    logic [63:0] r_drv_feat, n_drv_feat;
    logic [QW-1:0] r_sel,    n_sel;

    // Per-queue state
    logic [31:0] r_q_size  [MAX_QUEUES];
    logic [31:0] n_q_size  [MAX_QUEUES];
    logic [31:0] r_q_ready [MAX_QUEUES];
    logic [31:0] n_q_ready [MAX_QUEUES];
    logic [63:0] r_q_desc  [MAX_QUEUES];
    logic [63:0] n_q_desc  [MAX_QUEUES];
    logic [63:0] r_q_avail [MAX_QUEUES];
    logic [63:0] n_q_avail [MAX_QUEUES];
    logic [63:0] r_q_used  [MAX_QUEUES];
    logic [63:0] n_q_used  [MAX_QUEUES];
    logic [MAX_QUEUES-1:0] r_evidx, n_evidx;

    vmmio_pkg::t_result r_res, n_res;

    logic [MAX_QUEUES-1:0] q_live;
    logic [31:0]           wdata;
    logic                  idx_ok;
    logic [63:0]           feat_new;

    // Queue existence and write-value range check
    always_comb begin
        for (int i = 0; i < MAX_QUEUES; i++) begin
            q_live[i] = ({30'd0, r_num_q} > 32'(i));
        end
    end

    assign wdata  = i_item.write_data;
    assign idx_ok = (wdata < {30'd0, r_num_q}) && (wdata < 32'(MAX_QUEUES));
    assign feat_new = r_drv_feat | (r_drv_sel ? {wdata, 32'd0} : {32'd0, wdata});

    // Access decode and next state
    always_comb begin
        n_status   = r_status;
        n_irq      = r_irq;
        n_dev_sel  = r_dev_sel;
        n_drv_sel  = r_drv_sel;
        n_drv_feat = r_drv_feat;
        n_sel      = r_sel;
        n_q_size   = r_q_size;
        n_q_ready  = r_q_ready;
        n_q_desc   = r_q_desc;
        n_q_avail  = r_q_avail;
        n_q_used   = r_q_used;
        n_evidx    = r_evidx;
        n_res      = '0;

        if (i_cmd.exec) begin
            case (i_item.func)
                vmmio_pkg::FN_IRQ: begin
                    n_irq = r_irq | 32'd1;
                end
                vmmio_pkg::FN_READ, vmmio_pkg::FN_WRITE: begin
                    if (i_item.reg_offset >= vmmio_pkg::CONFIG_BASE) begin
                        n_res.error_code = vmmio_pkg::ERR_CFG_SPACE;
                    end else if (i_item.access_size != vmmio_pkg::ACCESS_BYTES) begin
                        n_res.error_code = vmmio_pkg::ERR_SIZE;
                    end else if (i_item.func == vmmio_pkg::FN_READ) begin
                        // Register reads
                        case (i_item.reg_offset)
                            vmmio_pkg::OFF_MAGIC:
                                n_res.read_data = vmmio_pkg::MAGIC_WORD;
                            vmmio_pkg::OFF_VERSION:
                                n_res.read_data = vmmio_pkg::VERSION_WORD;
                            vmmio_pkg::OFF_DEVICE_ID:
                                n_res.read_data = {24'd0, r_dev_id};
                            vmmio_pkg::OFF_VENDOR_ID:
                                n_res.read_data = r_vendor;
                            vmmio_pkg::OFF_DEV_FEAT:
                                n_res.read_data = r_dev_sel ? r_offered[63:32]
                                                            : r_offered[31:0];
                            vmmio_pkg::OFF_QUEUE_NUM_MAX:
                                n_res.read_data = {16'd0, r_q_max};
                            vmmio_pkg::OFF_QUEUE_READY:
                                n_res.read_data = r_q_ready[r_sel];
                            vmmio_pkg::OFF_IRQ_STATUS:
                                n_res.read_data = r_irq;
                            vmmio_pkg::OFF_STATUS:
                                n_res.read_data = r_status;
                            vmmio_pkg::OFF_CFG_GEN:
                                n_res.read_data = '0;
                            vmmio_pkg::OFF_DEV_FEAT_SEL, vmmio_pkg::OFF_DRV_FEAT,
                            vmmio_pkg::OFF_DRV_FEAT_SEL, vmmio_pkg::OFF_QUEUE_SEL,
                            vmmio_pkg::OFF_QUEUE_NUM, vmmio_pkg::OFF_QUEUE_NOTIFY,
                            vmmio_pkg::OFF_IRQ_ACK, vmmio_pkg::OFF_DESC_LO,
                            vmmio_pkg::OFF_DESC_HI, vmmio_pkg::OFF_AVAIL_LO,
                            vmmio_pkg::OFF_AVAIL_HI, vmmio_pkg::OFF_USED_LO,
                            vmmio_pkg::OFF_USED_HI:
                                n_res.error_code = vmmio_pkg::ERR_WO_READ;
                            default:
                                n_res.error_code = vmmio_pkg::ERR_BAD_OFF;
                        endcase
                    end else begin
                        // Register writes
                        case (i_item.reg_offset)
                            vmmio_pkg::OFF_DEV_FEAT_SEL: n_dev_sel = |wdata;
                            vmmio_pkg::OFF_DRV_FEAT: begin
                                n_drv_feat = feat_new;
                                if (feat_new[vmmio_pkg::EVENT_IDX_BIT]) begin
                                    n_evidx = r_evidx | q_live;
                                end
                            end
                            vmmio_pkg::OFF_DRV_FEAT_SEL: n_drv_sel = |wdata;
                            vmmio_pkg::OFF_QUEUE_SEL: begin
                                if (idx_ok) n_sel = wdata[QW-1:0];
                            end
                            vmmio_pkg::OFF_QUEUE_NUM:   n_q_size[r_sel]  = wdata;
                            vmmio_pkg::OFF_QUEUE_READY: n_q_ready[r_sel] = wdata;
                            vmmio_pkg::OFF_QUEUE_NOTIFY: begin
                                if (idx_ok) begin
                                    n_res.notify_valid = 1'b1;
                                    n_res.notify_queue = wdata[0];
                                end
                            end
                            vmmio_pkg::OFF_IRQ_ACK: n_irq = r_irq & ~wdata;
                            vmmio_pkg::OFF_STATUS: begin
                                n_status = wdata;
                                // Status zero resets the device side
                                if (wdata == '0) begin
                                    n_irq     = '0;
                                    n_q_size  = '{default: '0};
                                    n_q_ready = '{default: '0};
                                    n_q_desc  = '{default: '0};
                                    n_q_avail = '{default: '0};
                                    n_q_used  = '{default: '0};
                                    n_evidx   = '0;
                                    n_res.reset_done = 1'b1;
                                end
                            end
                            vmmio_pkg::OFF_DESC_LO:
                                n_q_desc[r_sel] = r_q_desc[r_sel] | {32'd0, wdata};
                            vmmio_pkg::OFF_DESC_HI:
                                n_q_desc[r_sel] = r_q_desc[r_sel] | {wdata, 32'd0};
                            vmmio_pkg::OFF_AVAIL_LO:
                                n_q_avail[r_sel] = r_q_avail[r_sel] | {32'd0, wdata};
                            vmmio_pkg::OFF_AVAIL_HI:
                                n_q_avail[r_sel] = r_q_avail[r_sel] | {wdata, 32'd0};
                            vmmio_pkg::OFF_USED_LO:
                                n_q_used[r_sel] = r_q_used[r_sel] | {32'd0, wdata};
                            vmmio_pkg::OFF_USED_HI:
                                n_q_used[r_sel] = r_q_used[r_sel] | {wdata, 32'd0};
                            vmmio_pkg::OFF_MAGIC, vmmio_pkg::OFF_VERSION,
                            vmmio_pkg::OFF_DEVICE_ID, vmmio_pkg::OFF_VENDOR_ID,
                            vmmio_pkg::OFF_DEV_FEAT, vmmio_pkg::OFF_QUEUE_NUM_MAX,
                            vmmio_pkg::OFF_IRQ_STATUS, vmmio_pkg::OFF_CFG_GEN:
                                n_res.error_code = vmmio_pkg::ERR_RO_WRITE;
                            default:
                                n_res.error_code = vmmio_pkg::ERR_BAD_OFF;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id  <= vmmio_pkg::RST_DEVICE_ID;
            r_vendor  <= '0;
            r_offered <= '0;
            r_num_q   <= vmmio_pkg::RST_NUM_QUEUES;
            r_q_max   <= vmmio_pkg::RST_QUEUE_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vmmio_pkg::CFG_DEVICE_ID:  r_dev_id  <= i_cfg_data[7:0];
                vmmio_pkg::CFG_VENDOR_ID:  r_vendor  <= i_cfg_data[31:0];
                vmmio_pkg::CFG_FEATURES:   r_offered <= i_cfg_data;
                vmmio_pkg::CFG_NUM_QUEUES: r_num_q   <= i_cfg_data[1:0];
                vmmio_pkg::CFG_QUEUE_MAX:  r_q_max   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Device and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= '0;
            r_irq      <= '0;
            r_dev_sel  <= 1'b0;
            r_drv_sel  <= 1'b0;
            r_drv_feat <= '0;
            r_sel      <= '0;
            r_q_size   <= '{default: '0};
            r_q_ready  <= '{default: '0};
            r_q_desc   <= '{default: '0};
            r_q_avail  <= '{default: '0};
            r_q_used   <= '{default: '0};
            r_evidx    <= '0;
        end else begin
            r_status   <= n_status;
            r_irq      <= n_irq;
            r_dev_sel  <= n_dev_sel;
            r_drv_sel  <= n_drv_sel;
            r_drv_feat <= n_drv_feat;
            r_sel      <= n_sel;
            r_q_size   <= n_q_size;
            r_q_ready  <= n_q_ready;
            r_q_desc   <= n_q_desc;
            r_q_avail  <= n_q_avail;
            r_q_used   <= n_q_used;
            r_evidx    <= n_evidx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;

endmodule

// File: sv/virtio_mmio_register_block.sv
// ----------------------------------------------------------------------------
// virtio_mmio_register_block
// Register side of a virtio-mmio transport (version 2 register map).
// ----------------------------------------------------------------------------
//  Channel   Handshake                     Payload
//  --------  ----------------------------  --------------------------------
//  item in   start && !busy                i_item   (vmmio_pkg::t_item)
//  result    o_done, one cycle, no stall   o_result (vmmio_pkg::t_result)
//  config    i_cfg_valid && o_cfg_ready    i_cfg_index, i_cfg_data
//
//  One item per cycle: decode and state update happen in the cycle the item
//  is taken, and its result is strobed on o_done in the following cycle.
//  The register update path from the item to the state registers sets that.
//  busy is high only while reset is held.
//  Config writes are taken every cycle (o_cfg_ready is always high).
// ----------------------------------------------------------------------------
module virtio_mmio_register_block #(
    parameter int MAX_QUEUES = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  vmmio_pkg::t_item   i_item,
    output logic               o_done,
    output vmmio_pkg::t_result o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    vmmio_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    vmmio_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    vmmio_dp #(
        .MAX_QUEUES (MAX_QUEUES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

// File: sv/vmmio_chk.sv
// ----------------------------------------------------------------------------
// vmmio_chk
// Port-level checker of the virtio-mmio register block, bound to the top.
// ----------------------------------------------------------------------------
`include "virtio_mmio_register_block_assert.svh"

module vmmio_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  vmmio_pkg::t_item   i_item,
    input  logic               o_done,
    input  vmmio_pkg::t_result o_result
);

    logic take;
    logic irq_take;

    assign take     = start & ~busy;
    assign irq_take = take & (i_item.func == vmmio_pkg::FN_IRQ);

    // Every item gives exactly one result, in the next cycle
    `VMMIO_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, take, o_done, "item without result")
    `VMMIO_ASSERT_NEXT(a_no_extra, i_clk, i_rst_n, !take, !o_done, "result without item")

    // Failed accesses read as zero and do nothing else
    `VMMIO_ASSERT_NOW(a_err_clean, i_clk, i_rst_n,
        o_done && (o_result.error_code != vmmio_pkg::ERR_OK),
        (o_result.read_data == '0) && !o_result.notify_valid && !o_result.reset_done,
        "error result carries data")

    // Interrupt events report nothing
    `VMMIO_ASSERT_NEXT(a_irq_zero, i_clk, i_rst_n, irq_take, o_result == '0,
        "interrupt event gave a nonzero result")

endmodule

bind virtio_mmio_register_block vmmio_chk u_vmmio_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);
